FILE: design/quoted_word_splitter_defines.svh
// Assertion macros shared by the quoted word splitter RTL.
`ifndef QUOTED_WORD_SPLITTER_DEFINES_SVH
`define QUOTED_WORD_SPLITTER_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked on every rising edge of clk outside reset.
`define QWS_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("quoted_word_splitter: check failed");
// Next-cycle implication, checked on every rising edge of clk outside reset.
`define QWS_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("quoted_word_splitter: check failed");
`else
`define QWS_ASSERT_IMP(lbl, pre, post)
`define QWS_ASSERT_NXT(lbl, pre, post)
`endif
`endif

FILE: design/qws_pkg.sv
// Types and constants of the quoted word splitter.
`default_nettype none
package qws_pkg;

  localparam logic [7:0] SEP_LIMIT      = 8'd33;
  localparam logic [7:0] QUOTE_BYTE     = 8'd34;
  localparam logic [7:0] BACKSLASH_BYTE = 8'd92;

  localparam logic [1:0] KIND_CHAR     = 2'd0;
  localparam logic [1:0] KIND_WORD_END = 2'd1;
  localparam logic [1:0] KIND_LINE_END = 2'd2;

  localparam int unsigned MAX_RESULTS = 4;

  typedef enum logic [1:0] {
    MODE_BETWEEN = 2'd0,
    MODE_PLAIN   = 2'd1,
    MODE_QUOTED  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       byte_valid;
    logic       line_end;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_value;
    logic       last;
  } out_t;

  typedef struct packed {
    mode_t mode;
    logic  pend_bs;
    logic  has_content;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{mode: MODE_BETWEEN, pend_bs: 1'b0,
                                         has_content: 1'b0};

  function automatic out_t mk_result(input logic [1:0] kind, input logic [7:0] ch);
    out_t r;
    r.kind       = kind;
    r.char_value = (kind == KIND_CHAR) ? ch : 8'd0;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/qws_step.sv
// Per-beat scanner: result list and next scan state for one input beat.
`default_nettype none
module qws_step (
  input  wire qws_pkg::scan_state_t    st,
  input  wire                          split_high,
  input  wire qws_pkg::in_t            item,
  output qws_pkg::scan_state_t         st_nxt,
  output qws_pkg::out_t [3:0]          res_list,
  output logic [2:0]                   res_cnt
);

  qws_pkg::scan_state_t st_mid;
  logic                 is_sep;
  logic                 is_quote;
  logic                 is_bs;
  logic [7:0]           b;

  assign b        = item.byte_value;
  assign is_sep   = (b < qws_pkg::SEP_LIMIT) || (split_high && b[7]);
  assign is_quote = (b == qws_pkg::QUOTE_BYTE);
  assign is_bs    = (b == qws_pkg::BACKSLASH_BYTE);

  // Next state: the byte first, then the line close.
  always_comb begin
    st_mid = st;
    if (item.byte_valid) begin
      case (st.mode)
        qws_pkg::MODE_PLAIN: begin
          if (is_sep) st_mid.mode = qws_pkg::MODE_BETWEEN;
        end
        qws_pkg::MODE_QUOTED: begin
          st_mid.has_content = 1'b1;
          if (st.pend_bs) begin
            if (!is_bs) st_mid.pend_bs = 1'b0;
          end else if (is_quote) begin
            st_mid.mode        = qws_pkg::MODE_BETWEEN;
            st_mid.has_content = 1'b0;
          end else if (is_bs) begin
            st_mid.pend_bs = 1'b1;
          end
        end
        default: begin
          if (!is_sep) begin
            if (is_quote) begin
              st_mid.mode        = qws_pkg::MODE_QUOTED;
              st_mid.pend_bs     = 1'b0;
              st_mid.has_content = 1'b0;
            end else begin
              st_mid.mode = qws_pkg::MODE_PLAIN;
            end
          end
        end
      endcase
    end
    st_nxt = item.line_end ? qws_pkg::SCAN_RESET : st_mid;
  end

  // Result list, appended in emission order.
  always_comb begin
    res_list = '0;
    res_cnt  = 3'd0;
    if (item.byte_valid) begin
      case (st.mode)
        qws_pkg::MODE_PLAIN: begin
          if (is_sep) begin
            res_list[res_cnt[1:0]] = qws_pkg::mk_result(qws_pkg::KIND_WORD_END, 8'd0);
          end else begin
            res_list[res_cnt[1:0]] = qws_pkg::mk_result(qws_pkg::KIND_CHAR, b);
          end
          res_cnt = res_cnt + 3'd1;
        end
        qws_pkg::MODE_QUOTED: begin
          if (st.pend_bs) begin
            // A held backslash is dropped only when a quote follows it.
            if (is_quote) begin
              res_list[res_cnt[1:0]] = qws_pkg::mk_result(qws_pkg::KIND_CHAR, b);
              res_cnt = res_cnt + 3'd1;
            end else begin
              res_list[res_cnt[1:0]] = qws_pkg::mk_result(qws_pkg::KIND_CHAR,
                                                          qws_pkg::BACKSLASH_BYTE);
              res_cnt = res_cnt + 3'd1;
              if (!is_bs) begin
                res_list[res_cnt[1:0]] = qws_pkg::mk_result(qws_pkg::KIND_CHAR, b);
                res_cnt = res_cnt + 3'd1;
              end
            end
          end else if (is_quote) begin
            res_list[res_cnt[1:0]] = qws_pkg::mk_result(qws_pkg::KIND_WORD_END, 8'd0);
            res_cnt = res_cnt + 3'd1;
          end else if (!is_bs) begin
            res_list[res_cnt[1:0]] = qws_pkg::mk_result(qws_pkg::KIND_CHAR, b);
            res_cnt = res_cnt + 3'd1;
          end
        end
        default: begin
          if (!is_sep && !is_quote) begin
            res_list[res_cnt[1:0]] = qws_pkg::mk_result(qws_pkg::KIND_CHAR, b);
            res_cnt = res_cnt + 3'd1;
          end
        end
      endcase
    end
    if (item.line_end) begin
      case (st_mid.mode)
        qws_pkg::MODE_PLAIN: begin
          res_list[res_cnt[1:0]] = qws_pkg::mk_result(qws_pkg::KIND_WORD_END, 8'd0);
          res_cnt = res_cnt + 3'd1;
        end
        qws_pkg::MODE_QUOTED: begin
          if (st_mid.pend_bs) begin
            res_list[res_cnt[1:0]] = qws_pkg::mk_result(qws_pkg::KIND_CHAR,
                                                        qws_pkg::BACKSLASH_BYTE);
            res_cnt = res_cnt + 3'd1;
          end
          // A lone opening quote yields no word at all.
          if (st_mid.has_content) begin
            res_list[res_cnt[1:0]] = qws_pkg::mk_result(qws_pkg::KIND_WORD_END, 8'd0);
            res_cnt = res_cnt + 3'd1;
          end
        end
        default: begin
        end
      endcase
      res_list[res_cnt[1:0]] = qws_pkg::mk_result(qws_pkg::KIND_LINE_END, 8'd0);
      res_cnt = res_cnt + 3'd1;
    end
  end

endmodule
`default_nettype wire

FILE: design/quoted_word_splitter.sv
// Quoted word splitter: splits a byte stream into words, zero to four results per beat.
//
// Input channel (in_valid / in_stall / in_data): one byte of a line per beat,
// with flags for "byte present" and "line ends here". Output channel
// (out_valid / out_stall / out_data): word characters, end-of-word marks and
// an end-of-line mark, with last set on the final result of each input beat.
// Configuration: cfg_we / cfg_wdata write split_high_bytes (reset value 1).
//
// An input beat is scanned in the cycle it is accepted and its zero to four
// results are loaded into a result list. The list drains one result per cycle,
// while the output register is free, into the output register, so each result
// passes through the list register and then the output register. The output
// port moves at most one result per cycle; beats that give at most one result
// stream at one per cycle while the receiver does not stall.
// The next beat is accepted while the last result of the previous one still
// waits in the output register. When the receiver stalls, the output register
// holds its result and the input stalls once the list is also occupied.
// Synchronous reset empties the list and output register and returns the
// scanner to the between-words state.
`default_nettype none
`include "quoted_word_splitter_defines.svh"
module quoted_word_splitter (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire qws_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output qws_pkg::out_t      out_data,
  input  wire                cfg_we,
  input  wire                cfg_wdata
);

  logic                 split_high_r;
  qws_pkg::scan_state_t st_r;
  qws_pkg::scan_state_t st_nxt;
  qws_pkg::out_t [3:0]  list_r;
  qws_pkg::out_t [3:0]  step_list;
  logic [2:0]           step_cnt;
  logic [2:0]           rem_r;
  logic [1:0]           rd_idx_r;
  logic                 out_valid_r;
  qws_pkg::out_t        out_data_r;
  logic                 list_busy;
  logic                 out_free;
  logic                 move;
  logic                 list_done;
  logic                 accept;

  qws_step u_step (
    .st         (st_r),
    .split_high (split_high_r),
    .item       (in_data),
    .st_nxt     (st_nxt),
    .res_list   (step_list),
    .res_cnt    (step_cnt)
  );

  assign list_busy = (rem_r != 3'd0);
  assign out_free  = !out_valid_r || !out_stall;
  assign move      = list_busy && out_free;
  // The list can take a new beat once its final entry leaves this cycle.
  assign list_done = !list_busy || (move && (rem_r == 3'd1));
  assign in_stall  = !list_done;
  assign accept    = in_valid && list_done;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_high_r <= 1'b1;
    end else if (cfg_we) begin
      split_high_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= qws_pkg::SCAN_RESET;
      rem_r    <= 3'd0;
      rd_idx_r <= 2'd0;
    end else if (accept) begin
      st_r     <= st_nxt;
      rem_r    <= step_cnt;
      rd_idx_r <= 2'd0;
    end else if (move) begin
      rem_r    <= rem_r - 3'd1;
      rd_idx_r <= rd_idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      list_r <= step_list;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= move;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data_r <= '{kind: list_r[rd_idx_r].kind, char_value: list_r[rd_idx_r].char_value,
                      last: (rem_r == 3'd1)};
    end
  end

  `QWS_ASSERT_IMP(a_idle_list_no_stall, rem_r == 3'd0, !in_stall)
  `QWS_ASSERT_NXT(a_list_fills_output, (rem_r != 3'd0) && !out_valid_r, out_valid_r)
  `QWS_ASSERT_NXT(a_line_end_resets, accept && in_data.line_end, st_r == qws_pkg::SCAN_RESET)

endmodule
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the quoted word splitter with a built-in line scanner model.
module testbench;

  localparam int DUE_DEPTH = 64;

  logic           clk;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  qws_pkg::in_t   in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  qws_pkg::out_t  out_data;
  logic           cfg_we = 1'b0;
  logic           cfg_wdata = 1'b0;

  // Scanner state of the prediction, modelled on the block's scanner.
  qws_pkg::mode_t scan_mode_q = qws_pkg::MODE_BETWEEN;
  bit    held_backslash = 1'b0;
  bit    quoted_seen = 1'b0;
  bit    split_high_q = 1'b1;

  // Expected results, kept as a ring with running write and read counts.
  qws_pkg::out_t tokens_due [0:DUE_DEPTH-1];
  int    due_wr = 0;
  int    due_rd = 0;
  int    errors = 0;
  bit    gaps_on = 1'b1;
  bit    stall_on = 1'b1;
  int    stall_left = 0;

  quoted_word_splitter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[quoted_word_splitter] ERROR");
    $finish;
  end

  function automatic int idle_length();
    if ($urandom_range(0, 9) == 0) begin
      return int'($urandom_range(8, 30));
    end
    return int'($urandom_range(1, 3));
  endfunction

  function automatic bit is_splitter(logic [7:0] b);
    return (b < qws_pkg::SEP_LIMIT) || (split_high_q && b[7]);
  endfunction

  function automatic void note(logic [1:0] kind, logic [7:0] ch);
    qws_pkg::out_t r;
    r.kind       = kind;
    r.char_value = (kind == qws_pkg::KIND_CHAR) ? ch : 8'd0;
    r.last       = 1'b0;
    tokens_due[due_wr % DUE_DEPTH] = r;
    due_wr++;
  endfunction

  // Works out the results of one accepted beat and queues them.
  function automatic void tokenize_item(qws_pkg::in_t item);
    logic [7:0] b;
    int         first;
    b = item.byte_value;
    first = due_wr;
    if (item.byte_valid) begin
      case (scan_mode_q)
        qws_pkg::MODE_PLAIN: begin
          if (is_splitter(b)) begin
            note(qws_pkg::KIND_WORD_END, 8'd0);
            scan_mode_q = qws_pkg::MODE_BETWEEN;
          end else begin
            note(qws_pkg::KIND_CHAR, b);
          end
        end
        qws_pkg::MODE_QUOTED: begin
          quoted_seen = 1'b1;
          if (held_backslash) begin
            // A run of backslashes stays held until a non-backslash shows up.
            if (b == qws_pkg::QUOTE_BYTE) begin
              note(qws_pkg::KIND_CHAR, b);
              held_backslash = 1'b0;
            end else if (b == qws_pkg::BACKSLASH_BYTE) begin
              note(qws_pkg::KIND_CHAR, qws_pkg::BACKSLASH_BYTE);
            end else begin
              note(qws_pkg::KIND_CHAR, qws_pkg::BACKSLASH_BYTE);
              note(qws_pkg::KIND_CHAR, b);
              held_backslash = 1'b0;
            end
          end else if (b == qws_pkg::QUOTE_BYTE) begin
            note(qws_pkg::KIND_WORD_END, 8'd0);
            scan_mode_q = qws_pkg::MODE_BETWEEN;
            quoted_seen = 1'b0;
          end else if (b == qws_pkg::BACKSLASH_BYTE) begin
            held_backslash = 1'b1;
          end else begin
            note(qws_pkg::KIND_CHAR, b);
          end
        end
        default: begin
          if (!is_splitter(b)) begin
            if (b == qws_pkg::QUOTE_BYTE) begin
              scan_mode_q = qws_pkg::MODE_QUOTED;
              held_backslash = 1'b0;
              quoted_seen = 1'b0;
            end else begin
              scan_mode_q = qws_pkg::MODE_PLAIN;
              note(qws_pkg::KIND_CHAR, b);
            end
          end
        end
      endcase
    end
    if (item.line_end) begin
      if (scan_mode_q == qws_pkg::MODE_PLAIN) begin
        note(qws_pkg::KIND_WORD_END, 8'd0);
      end else if (scan_mode_q == qws_pkg::MODE_QUOTED) begin
        if (held_backslash) begin
          note(qws_pkg::KIND_CHAR, qws_pkg::BACKSLASH_BYTE);
        end
        if (quoted_seen) begin
          note(qws_pkg::KIND_WORD_END, 8'd0);
        end
      end
      note(qws_pkg::KIND_LINE_END, 8'd0);
      scan_mode_q = qws_pkg::MODE_BETWEEN;
      held_backslash = 1'b0;
      quoted_seen = 1'b0;
    end
    if (due_wr > first) begin
      tokens_due[(due_wr - 1) % DUE_DEPTH].last = 1'b1;
    end
  endfunction

  task automatic send_item(logic [7:0] b, bit valid, bit eol);
    int gap;
    gap = (gaps_on && $urandom_range(0, 2) == 0) ? idle_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= '{byte_value: b, byte_valid: valid, line_end: eol};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    tokenize_item('{byte_value: b, byte_valid: valid, line_end: eol});
  endtask

  // Lets every queued result drain, then gives the block time to finish
  // beats that produce nothing.
  task automatic settle();
    in_valid <= 1'b0;
    while (due_wr != due_rd) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_split_high(bit value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    split_high_q = value;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1:    return qws_pkg::QUOTE_BYTE;
      2:       return qws_pkg::BACKSLASH_BYTE;
      3:       return 8'($urandom_range(0, 32));
      4:       return 8'($urandom_range(128, 255));
      5:       return 8'($urandom);
      default: return 8'($urandom_range(33, 126));
    endcase
  endfunction

  task automatic send_random_line(output int counted);
    int n;
    bit valid;
    bit eol;
    n = $urandom_range(1, 12);
    counted = 0;
    for (int i = 0; i < n; i++) begin
      valid = ($urandom_range(0, 9) != 0);
      eol   = (i == n - 1);
      if (valid || eol) begin
        counted++;
      end
      send_item(pick_byte(), valid, eol);
    end
  endtask

  task automatic test_plain_words();
    send_item(8'h21, 1'b1, 1'b0);
    send_item(qws_pkg::QUOTE_BYTE, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'h20, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h78, 1'b1, 1'b1);
  endtask

  task automatic test_quoted_words();
    send_item(qws_pkg::QUOTE_BYTE, 1'b1, 1'b0);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h20, 1'b1, 1'b0);
    send_item(qws_pkg::BACKSLASH_BYTE, 1'b1, 1'b0);
    send_item(qws_pkg::QUOTE_BYTE, 1'b1, 1'b0);
    // A doubled backslash before a quote still keeps the word open.
    send_item(qws_pkg::BACKSLASH_BYTE, 1'b1, 1'b0);
    send_item(qws_pkg::BACKSLASH_BYTE, 1'b1, 1'b0);
    send_item(qws_pkg::QUOTE_BYTE, 1'b1, 1'b0);
    send_item(qws_pkg::BACKSLASH_BYTE, 1'b1, 1'b0);
    send_item(8'h71, 1'b1, 1'b0);
    send_item(qws_pkg::QUOTE_BYTE, 1'b1, 1'b0);
    send_item(qws_pkg::QUOTE_BYTE, 1'b1, 1'b0);
    send_item(qws_pkg::QUOTE_BYTE, 1'b1, 1'b0);
    send_item(qws_pkg::QUOTE_BYTE, 1'b1, 1'b1);
  endtask

  task automatic test_unterminated_lines();
    send_item(qws_pkg::QUOTE_BYTE, 1'b1, 1'b0);
    send_item(qws_pkg::BACKSLASH_BYTE, 1'b1, 1'b0);
    send_item(8'h7A, 1'b1, 1'b1);
    send_item(qws_pkg::QUOTE_BYTE, 1'b1, 1'b0);
    send_item(qws_pkg::BACKSLASH_BYTE, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b0);
  endtask

  task automatic test_high_bytes_as_text();
    settle();
    write_split_high(1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h20, 1'b1, 1'b1);
  endtask

  task automatic test_random_lines(int target);
    int sent;
    int got;
    sent = 0;
    while (sent < target) begin
      gaps_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      send_random_line(got);
      sent += got;
    end
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  // Receiver back-pressure: one assignment of out_stall per clock edge.
  initial begin
    forever begin
      @(posedge clk);
      if (stall_left == 0 && stall_on && $urandom_range(0, 3) == 0) begin
        stall_left = idle_length();
      end
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    qws_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_wr == due_rd) begin
        $error("result with nothing expected: kind %0d char %02h last %0d",
               out_data.kind, out_data.char_value, out_data.last);
        errors++;
      end else begin
        want = tokens_due[due_rd % DUE_DEPTH];
        due_rd++;
        if (out_data.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_data.kind);
          errors++;
        end
        if (out_data.char_value !== want.char_value) begin
          $error("char_value: expected %02h, got %02h", want.char_value, out_data.char_value);
          errors++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data.last);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_plain_words();
    test_quoted_words();
    test_unterminated_lines();
    test_high_bytes_as_text();
    test_random_lines(35);
    settle();
    write_split_high(1'b1);
    test_random_lines(35);
    settle();
    if (errors == 0 && due_wr == due_rd) begin
      $display("[quoted_word_splitter] OK");
    end else begin
      $display("[quoted_word_splitter] ERROR");
    end
    $finish;
  end

endmodule
